>>> hw/rtl/csem_pkg.sv
// Package for the counting semaphore unit: table sizes, status codes,
// request and response item types, and a small helper.
// No dependencies.
`timescale 1ns / 1ps

package csem_pkg;

  localparam int NUM_TASKS = 8;
  localparam int NUM_SEMS  = 16;
  localparam int TASK_W    = 3;
  localparam int SEM_W     = 4;
  localparam int CNT_W     = 8;

  localparam logic [1:0] ACT_DOWN = 2'd0;
  localparam logic [1:0] ACT_TRY  = 2'd1;
  localparam logic [1:0] ACT_UP   = 2'd2;

  localparam logic [2:0] ST_ACQUIRED   = 3'd0;
  localparam logic [2:0] ST_BLOCKED    = 3'd1;
  localparam logic [2:0] ST_TRY_FAILED = 3'd2;
  localparam logic [2:0] ST_UP_DONE    = 3'd3;
  localparam logic [2:0] ST_UP_IGNORED = 3'd4;

  typedef struct packed {
    logic [1:0]       action;
    logic [SEM_W-1:0] sem_index;
    logic [2:0]       task_id;
    logic [7:0]       amount;
    logic [2:0]       start_task;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] count_after;
    logic [7:0] waiters_after;
    logic [7:0] released_mask;
    logic [7:0] task_waiting_flags;
  } rsp_t;

  typedef struct packed {
    logic              block;
    logic              release_en;
    logic [TASK_W-1:0] id;
  } task_cmd_t;

  function automatic logic task_valid(input logic [2:0] id);
    return (32'(id) < NUM_TASKS);
  endfunction

endpackage

>>> hw/rtl/csem_task_tbl.sv
// Per-task wait counts and waiting flags, updated by block and release commands.
// Depends on csem_pkg.
`timescale 1ns / 1ps

module csem_task_tbl
  import csem_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  task_cmd_t            cmd,
  output logic [NUM_TASKS-1:0] flags
);

  logic [CNT_W-1:0] wait_count [NUM_TASKS];
  logic [CNT_W-1:0] dec_count;

  assign dec_count = (wait_count[cmd.id] != '0) ? wait_count[cmd.id] - 1'b1
                                                 : wait_count[cmd.id];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_TASKS; i++) begin
        wait_count[i] <= '0;
      end
      flags <= '0;
    end else if (cmd.block) begin
      if (wait_count[cmd.id] != '1) begin
        wait_count[cmd.id] <= wait_count[cmd.id] + 1'b1;
      end
      flags[cmd.id] <= 1'b1;
    end else if (cmd.release_en) begin
      wait_count[cmd.id] <= dec_count;
      if (dec_count == '0) begin
        flags[cmd.id] <= 1'b0;
      end
    end
  end

endmodule

>>> hw/rtl/csem_wake_step.sv
// One step of the round-robin wake scan: test one waiter bit, release it,
// spend one unit and decide whether the scan ends. Depends on csem_pkg.
`timescale 1ns / 1ps

module csem_wake_step
  import csem_pkg::*;
(
  input  logic [NUM_TASKS-1:0] waiters,
  input  logic [CNT_W-1:0]     count,
  input  logic [TASK_W-1:0]    id,
  input  logic [TASK_W-1:0]    first,
  output logic                 hit,
  output logic [NUM_TASKS-1:0] waiters_next,
  output logic [CNT_W-1:0]     count_next,
  output logic [TASK_W-1:0]    id_next,
  output logic                 stop
);

  logic [NUM_TASKS-1:0] bit_sel;

  always_comb begin
    bit_sel      = NUM_TASKS'(1) << id;
    hit          = (waiters & bit_sel) != '0;
    waiters_next = hit ? (waiters & ~bit_sel) : waiters;
    count_next   = hit ? count - 1'b1 : count;
    id_next      = (32'(id) == NUM_TASKS - 1) ? '0 : id + 1'b1;
    stop         = (hit && count_next == '0) || (id_next == first) || (waiters_next == '0);
  end

endmodule

>>> hw/rtl/counting_semaphore_wait_mask_unit.sv
// Counting semaphore unit with waiter masks: semaphore table, sequencer and
// output register. Depends on csem_pkg, csem_task_tbl and csem_wake_step.
// Timing: an item is taken only while the unit is idle. A down, try-down, an
// up by zero or an up with no waiters goes from the execute state straight
// to the done state; an up with waiters first runs the wake scan, visiting
// 1 to 8 task ids. The unit takes its next item the cycle after the result
// is loaded into the output register, which waits while the output stalls;
// the single wake-step unit walks the waiter mask one bit a cycle.
`timescale 1ns / 1ps

module counting_semaphore_wait_mask_unit
  import csem_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]           state;
  logic [1:0]           state_next;
  req_t                 cur;
  logic [CNT_W-1:0]     cnt;
  logic [CNT_W-1:0]     cnt_next;
  logic [NUM_TASKS-1:0] wmask;
  logic [NUM_TASKS-1:0] wmask_next;
  logic [NUM_TASKS-1:0] rel;
  logic [NUM_TASKS-1:0] rel_next;
  logic [TASK_W-1:0]    id;
  logic [TASK_W-1:0]    id_next;
  logic [TASK_W-1:0]    first;
  logic [TASK_W-1:0]    first_next;
  logic [2:0]           status;
  logic [2:0]           status_next;

  logic [CNT_W-1:0]     count_mem   [NUM_SEMS];
  logic [NUM_TASKS-1:0] sem_waiters [NUM_SEMS];

  logic [CNT_W-1:0]     rd_count;
  logic [NUM_TASKS-1:0] rd_waiters;
  logic [CNT_W:0]       sum;
  logic [CNT_W-1:0]     sat_count;
  logic [TASK_W-1:0]    start_id;
  logic [TASK_W-1:0]    caller;

  logic                 st_hit;
  logic [NUM_TASKS-1:0] st_waiters;
  logic [CNT_W-1:0]     st_count;
  logic [TASK_W-1:0]    st_id;
  logic                 st_stop;

  task_cmd_t            tcmd;
  logic [NUM_TASKS-1:0] tflags;
  logic                 load_out;

  assign req_ready  = (state == S_IDLE) && !rst;
  assign sum        = {1'b0, rd_count} + {1'b0, cur.amount};
  assign sat_count  = sum[CNT_W] ? '1 : sum[CNT_W-1:0];
  assign start_id   = task_valid(cur.start_task) ? TASK_W'(cur.start_task) : '0;
  assign caller     = TASK_W'(cur.task_id);
  assign load_out   = (state == S_DONE) && (!rsp_valid || rsp_ready);

  csem_wake_step u_step (
    .waiters      (wmask),
    .count        (cnt),
    .id           (id),
    .first        (first),
    .hit          (st_hit),
    .waiters_next (st_waiters),
    .count_next   (st_count),
    .id_next      (st_id),
    .stop         (st_stop)
  );

  csem_task_tbl u_tasks (
    .clk   (clk),
    .rst   (rst),
    .cmd   (tcmd),
    .flags (tflags)
  );

  always_comb begin
    state_next  = state;
    cnt_next    = cnt;
    wmask_next  = wmask;
    rel_next    = rel;
    id_next     = id;
    first_next  = first;
    status_next = status;
    tcmd        = '{block: 1'b0, release_en: 1'b0, id: id};
    unique case (state)
      S_IDLE: begin
        if (req_valid && req_ready) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cnt_next   = rd_count;
        wmask_next = rd_waiters;
        rel_next   = '0;
        state_next = S_DONE;
        priority if (cur.action == ACT_DOWN || cur.action == ACT_TRY) begin
          if (rd_count != '0) begin
            cnt_next    = rd_count - 1'b1;
            status_next = ST_ACQUIRED;
          end else if (cur.action == ACT_TRY) begin
            status_next = ST_TRY_FAILED;
          end else begin
            status_next = ST_BLOCKED;
            if (task_valid(cur.task_id)) begin
              wmask_next = rd_waiters | (NUM_TASKS'(1) << caller);
              tcmd       = '{block: 1'b1, release_en: 1'b0, id: caller};
            end
          end
        end else if (cur.action == ACT_UP && cur.amount != '0) begin
          cnt_next    = sat_count;
          status_next = ST_UP_DONE;
          id_next     = start_id;
          first_next  = start_id;
          if (rd_waiters != '0) begin
            state_next = S_SCAN;
          end
        end else begin
          status_next = ST_UP_IGNORED;
        end
      end
      S_SCAN: begin
        cnt_next   = st_count;
        wmask_next = st_waiters;
        id_next    = st_id;
        if (st_hit) begin
          rel_next = rel | (NUM_TASKS'(1) << id);
          tcmd     = '{block: 1'b0, release_en: 1'b1, id: id};
        end
        if (st_stop) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (load_out) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      cur <= req;
    end
    cnt    <= cnt_next;
    wmask  <= wmask_next;
    rel    <= rel_next;
    id     <= id_next;
    first  <= first_next;
    status <= status_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_SEMS; i++) begin
        count_mem[i]   <= '0;
        sem_waiters[i] <= '0;
      end
    end else if (load_out) begin
      count_mem[cur.sem_index]   <= cnt;
      sem_waiters[cur.sem_index] <= wmask;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      rd_count   <= count_mem[req.sem_index];
      rd_waiters <= sem_waiters[req.sem_index];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load_out) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      rsp.status             <= status;
      rsp.count_after        <= cnt;
      rsp.waiters_after      <= 8'(wmask);
      rsp.released_mask      <= 8'(rel);
      rsp.task_waiting_flags <= 8'(tflags);
    end
  end

endmodule

>>> hw/rtl/csem_checker.sv
// Port-level checks for the counting semaphore unit, bound to the top level.
// Depends on csem_pkg.
`timescale 1ns / 1ps

module csem_checker
  import csem_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input logic rsp_valid,
  input logic rsp_ready,
  input rsp_t rsp
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("response item changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("item taken while previous one in progress");

  a_release_only_on_up: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != ST_UP_DONE |-> rsp.released_mask == '0)
    else $error("tasks released by a non-up item");

  a_released_not_waiting: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.released_mask & rsp.waiters_after) == '0)
    else $error("released task still in waiter mask");

  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !rsp_valid)
    else $error("response valid straight after reset");

endmodule

bind counting_semaphore_wait_mask_unit csem_checker u_csem_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);

>>> tb/sv/tb_counting_semaphore_wait_mask_unit.sv
// Testbench for counting_semaphore_wait_mask_unit: a queue-fed driver, a
// stalling receiver and a self-checking monitor with its own semaphore
// table. Depends on csem_pkg and the unit's RTL only.
`timescale 1ns / 1ps

module tb_counting_semaphore_wait_mask_unit;
  import csem_pkg::*;

  localparam logic [1:0] ACT_NONE = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  req_t pending_reqs[$];
  rsp_t expected_rsps[$];

  logic [7:0] sem_cnt_tbl   [NUM_SEMS];
  logic [7:0] sem_waiter_tbl[NUM_SEMS];
  logic [7:0] task_wait_tbl [NUM_TASKS];
  logic [7:0] wait_flags;

  int mismatches = 0;
  int burst_left = 1;
  int gap_left = 0;
  logic [9:0] stall_cycle = '0;
  rsp_t want;

  counting_semaphore_wait_mask_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic rsp_t apply_semaphore_op(input req_t r);
    rsp_t o;
    int s, cnt, id, first;
    logic [7:0] rel;
    logic done;
    s = int'(r.sem_index) % NUM_SEMS;
    rel = '0;
    o.status = ST_UP_IGNORED;
    case (r.action)
      ACT_DOWN: begin
        if (sem_cnt_tbl[s] != 8'd0) begin
          sem_cnt_tbl[s] = sem_cnt_tbl[s] - 8'd1;
          o.status = ST_ACQUIRED;
        end else begin
          o.status = ST_BLOCKED;
          if (int'(r.task_id) < NUM_TASKS) begin
            if (task_wait_tbl[r.task_id] != 8'd255)
              task_wait_tbl[r.task_id] = task_wait_tbl[r.task_id] + 8'd1;
            wait_flags[r.task_id] = 1'b1;
            sem_waiter_tbl[s][r.task_id] = 1'b1;
          end
        end
      end
      ACT_TRY: begin
        if (sem_cnt_tbl[s] != 8'd0) begin
          sem_cnt_tbl[s] = sem_cnt_tbl[s] - 8'd1;
          o.status = ST_ACQUIRED;
        end else begin
          o.status = ST_TRY_FAILED;
        end
      end
      ACT_UP: begin
        if (r.amount != 8'd0) begin
          cnt = int'(sem_cnt_tbl[s]) + int'(r.amount);
          if (cnt > 255) cnt = 255;
          o.status = ST_UP_DONE;
          if (sem_waiter_tbl[s] != 8'd0) begin
            id = (int'(r.start_task) < NUM_TASKS) ? int'(r.start_task) : 0;
            first = id;
            done = 1'b0;
            do begin
              if (sem_waiter_tbl[s][id]) begin
                sem_waiter_tbl[s][id] = 1'b0;
                rel[id] = 1'b1;
                cnt = cnt - 1;
                if (task_wait_tbl[id] != 8'd0) task_wait_tbl[id] = task_wait_tbl[id] - 8'd1;
                if (task_wait_tbl[id] == 8'd0) wait_flags[id] = 1'b0;
                if (cnt == 0) done = 1'b1;
              end
              if (!done) begin
                id = id + 1;
                if (id >= NUM_TASKS) id = 0;
              end
            end while (!done && id != first && sem_waiter_tbl[s] != 8'd0);
          end
          sem_cnt_tbl[s] = cnt[7:0];
        end
      end
      default: ;
    endcase
    o.count_after = sem_cnt_tbl[s];
    o.waiters_after = sem_waiter_tbl[s];
    o.released_mask = rel;
    o.task_waiting_flags = wait_flags;
    return o;
  endfunction

  task automatic queue_req(input logic [1:0] act, input logic [3:0] sem,
                           input logic [2:0] tid, input logic [7:0] amt,
                           input logic [2:0] st);
    req_t r;
    r.action = act;
    r.sem_index = sem;
    r.task_id = tid;
    r.amount = amt;
    r.start_task = st;
    pending_reqs.push_back(r);
  endtask

  // sender: bursts of items separated by random gaps
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && req_ready) begin
        expected_rsps.push_back(apply_semaphore_op(req));
      end
      if (!(req_valid && !req_ready)) begin
        if (gap_left > 0) begin
          gap_left = gap_left - 1;
          req_valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          req <= pending_reqs.pop_front();
          req_valid <= 1'b1;
          burst_left = burst_left - 1;
          if (burst_left <= 0) begin
            burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(1, 10);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 14);
          end
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: stall mode cycles through free, light, heavy and random
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      stall_cycle <= stall_cycle + 10'd1;
      case (stall_cycle[9:8])
        2'd0: rsp_ready <= 1'b1;
        2'd1: rsp_ready <= ($urandom_range(0, 3) != 0);
        2'd2: rsp_ready <= (stall_cycle[2:0] == 3'd5);
        default: rsp_ready <= ($urandom_range(0, 1) == 1);
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) begin
      if (expected_rsps.size() == 0) begin
        mismatches = mismatches + 1;
        if (mismatches <= 10)
          $display("unexpected item: status=%0d count=%0d waiters=%h released=%h flags=%h",
                   rsp.status, rsp.count_after, rsp.waiters_after, rsp.released_mask,
                   rsp.task_waiting_flags);
      end else begin
        want = expected_rsps.pop_front();
        if (rsp.status !== want.status || rsp.count_after !== want.count_after ||
            rsp.waiters_after !== want.waiters_after ||
            rsp.released_mask !== want.released_mask ||
            rsp.task_waiting_flags !== want.task_waiting_flags) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10) begin
            $display("mismatch exp: status=%0d count=%0d waiters=%h released=%h flags=%h",
                     want.status, want.count_after, want.waiters_after,
                     want.released_mask, want.task_waiting_flags);
            $display("         got: status=%0d count=%0d waiters=%h released=%h flags=%h",
                     rsp.status, rsp.count_after, rsp.waiters_after,
                     rsp.released_mask, rsp.task_waiting_flags);
          end
        end
      end
    end
  end

  initial begin
    int n_rand, k, n, i, s;
    for (i = 0; i < NUM_SEMS; i++) begin
      sem_cnt_tbl[i] = '0;
      sem_waiter_tbl[i] = '0;
    end
    for (i = 0; i < NUM_TASKS; i++) task_wait_tbl[i] = '0;
    wait_flags = '0;

    // directed: blocking, repeats, zero and unused ops, wrap, saturation
    queue_req(ACT_DOWN, 4'd0, 3'd0, 8'd0, 3'd0);
    queue_req(ACT_TRY, 4'd0, 3'd0, 8'd0, 3'd0);
    queue_req(ACT_DOWN, 4'd0, 3'd7, 8'd0, 3'd0);
    queue_req(ACT_DOWN, 4'd0, 3'd7, 8'd0, 3'd0);
    queue_req(ACT_DOWN, 4'd0, 3'd3, 8'd0, 3'd0);
    queue_req(ACT_UP, 4'd0, 3'd0, 8'd0, 3'd0);
    queue_req(ACT_NONE, 4'd0, 3'd7, 8'd255, 3'd7);
    queue_req(ACT_UP, 4'd0, 3'd0, 8'd1, 3'd5);
    queue_req(ACT_UP, 4'd0, 3'd0, 8'd255, 3'd7);
    queue_req(ACT_DOWN, 4'd0, 3'd7, 8'd0, 3'd0);
    queue_req(ACT_UP, 4'd15, 3'd0, 8'd255, 3'd0);
    queue_req(ACT_UP, 4'd15, 3'd0, 8'd200, 3'd0);
    queue_req(ACT_TRY, 4'd15, 3'd0, 8'd0, 3'd0);
    queue_req(ACT_DOWN, 4'd15, 3'd1, 8'd0, 3'd0);
    queue_req(ACT_DOWN, 4'd5, 3'd2, 8'd0, 3'd0);
    queue_req(ACT_DOWN, 4'd5, 3'd4, 8'd0, 3'd0);
    queue_req(ACT_DOWN, 4'd5, 3'd5, 8'd0, 3'd0);
    queue_req(ACT_UP, 4'd5, 3'd0, 8'd2, 3'd6);
    queue_req(ACT_UP, 4'd5, 3'd0, 8'd255, 3'd7);
    queue_req(ACT_DOWN, 4'd10, 3'd7, 8'd0, 3'd0);
    queue_req(ACT_UP, 4'd10, 3'd0, 8'd4, 3'd2);
    queue_req(ACT_UP, 4'd0, 3'd0, 8'd255, 3'd0);

    // random: mostly block-then-wake sequences, some loose items
    n_rand = 0;
    while (n_rand < 268) begin
      s = $urandom_range(0, 15);
      if (s == 14) s = $urandom_range(0, 3);
      if ($urandom_range(0, 9) < 6) begin
        k = $urandom_range(1, 6);
        for (i = 0; i < k; i++)
          queue_req(ACT_DOWN, 4'(s), 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                    3'($urandom_range(0, 7)));
        n = $urandom_range(1, 3);
        for (i = 0; i < n; i++)
          queue_req(ACT_UP, 4'(s), 3'($urandom_range(0, 7)),
                    8'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
                                                   : $urandom_range(1, 3)),
                    3'($urandom_range(0, 7)));
        n_rand = n_rand + k + n;
      end else begin
        queue_req(2'($urandom_range(0, 3)), 4'(s), 3'($urandom_range(0, 7)),
                  8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)));
        n_rand = n_rand + 1;
      end
    end

    // drive one task's wait count into saturation on an untouched semaphore
    for (i = 0; i < 258; i++) queue_req(ACT_DOWN, 4'd14, 3'd6, 8'd0, 3'd0);
    queue_req(ACT_UP, 4'd14, 3'd0, 8'd3, 3'd0);
    queue_req(ACT_DOWN, 4'd14, 3'd6, 8'd0, 3'd0);

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    wait (pending_reqs.size() == 0 && !req_valid);
    wait (expected_rsps.size() == 0);
    repeat (16) @(posedge clk);
    if (mismatches == 0 && expected_rsps.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
